>>> hdl/rrss_pkg.sv
// Shared types and codes for the round-robin sleep scheduler.
package rrss_pkg;

    typedef enum logic [1:0] {
        ST_UNUSED  = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_WAITING = 2'd3
    } t_slot_state;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_SLEEP  = 3'd1,
        OP_EXIT   = 3'd2,
        OP_ALARM  = 3'd3,
        OP_CREATE = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_WRITE = 3'b100
    } t_fsm;

    typedef struct packed {
        logic        tick;
        logic        set;
        t_slot_state state;
        logic        load_sleep;
        logic        create;
        logic        start;
        logic        shift;
    } t_cell_cmd;

    typedef struct packed {
        logic unused;
        logic running;
        logic hit_ready;
        logic hit_wait;
    } t_cell_stat;

endpackage

>>> hdl/rrss_cell.sv
// One task slot: its state, its sleep countdown and its place in the scan token ring.
module rrss_cell #(
    parameter int COUNT_BITS = 32,
    parameter bit IS_IDLE    = 1'b0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rrss_pkg::t_cell_cmd     i_cmd,
    input  logic                    i_sel,
    input  logic                    i_start,
    input  logic                    i_token,
    input  logic [COUNT_BITS-1:0]   i_sleep_val,
    output logic                    o_token,
    output rrss_pkg::t_cell_stat    o_stat
);

    rrss_pkg::t_slot_state r_state, n_state;
    logic [COUNT_BITS-1:0] r_sleep, n_sleep;
    logic                  r_token, n_token;

    always_comb begin
        n_state = r_state;
        n_sleep = r_sleep;
        if (i_cmd.tick && (r_sleep != '0)) begin
            n_sleep = r_sleep - 1'b1;
            if (r_sleep == COUNT_BITS'(1)) begin
                n_state = rrss_pkg::ST_READY;
            end
        end
        if (i_sel && i_cmd.set) begin
            n_state = i_cmd.state;
        end
        if (i_sel && i_cmd.load_sleep) begin
            n_sleep = i_sleep_val;
        end
        if (i_sel && i_cmd.create && !IS_IDLE && (r_state == rrss_pkg::ST_UNUSED)) begin
            n_state = rrss_pkg::ST_READY;
            n_sleep = '0;
        end
        if (i_cmd.start) begin
            n_token = i_start;
        end else if (i_cmd.shift) begin
            n_token = i_token;
        end else begin
            n_token = r_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IS_IDLE ? rrss_pkg::ST_RUNNING : rrss_pkg::ST_UNUSED;
            r_sleep <= '0;
            r_token <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sleep <= n_sleep;
            r_token <= n_token;
        end
    end

    assign o_token          = r_token;
    assign o_stat.unused    = (r_state == rrss_pkg::ST_UNUSED);
    assign o_stat.running   = (r_state == rrss_pkg::ST_RUNNING);
    assign o_stat.hit_ready = r_token && !IS_IDLE && (r_state == rrss_pkg::ST_READY);
    assign o_stat.hit_wait  = r_token && !IS_IDLE && (r_state == rrss_pkg::ST_WAITING);

endmodule

>>> hdl/round_robin_sleep_scheduler_core.sv
// Top level of the round-robin sleep scheduler: control sequencer and the row of slot cells.
// Each slot is a cell that keeps its own state and sleep countdown, and all counters step
// down together on a tick. Tick, sleep and exit pick the next slot by walking a token from
// the slot after the current one around the row, one cell per cycle, stopping at the first
// ready slot; the walk visits at most SLOT_COUNT - 1 cells. Set alarm, create and undefined
// codes skip the walk and go straight to the write state. A new beat is accepted while the
// previous result still waits in the output register.
module round_robin_sleep_scheduler_core #(
    parameter int SLOT_COUNT = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_tick_count,
    input  logic [3:0]  i_target_slot,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_next_slot,
    output logic        o_switched,
    output logic        o_alarm_fired,
    output logic        o_shutdown
);

    localparam int IDX_W = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
    localparam int CMP_W = (IDX_W > 4) ? IDX_W : 4;
    localparam int EXT_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    rrss_pkg::t_fsm        r_state, n_state;
    rrss_pkg::t_op         r_op, n_op;
    logic [IDX_W-1:0]      r_cur, n_cur;
    logic [IDX_W-1:0]      r_next, n_next;
    logic [IDX_W-1:0]      r_ptr, n_ptr;
    logic [IDX_W-1:0]      r_steps, n_steps;
    logic                  r_wait, n_wait;
    logic                  r_fired, n_fired;
    logic                  r_halt, n_halt;
    logic [COUNT_BITS-1:0] r_alarm_left, n_alarm_left;
    logic [3:0]            r_alarm_slot;
    logic                  r_out_valid, n_out_valid;
    logic [3:0]            r_out_slot, n_out_slot;
    logic                  r_out_sw, n_out_sw;
    logic                  r_out_fired, n_out_fired;
    logic                  r_out_halt, n_out_halt;

    rrss_pkg::t_cell_cmd   cmd;
    rrss_pkg::t_cell_stat  stat [SLOT_COUNT];
    logic [CMP_W-1:0]      sel_slot;
    logic [SLOT_COUNT-1:0] sel_vec, start_vec, token_vec;
    logic [SLOT_COUNT-1:0] unused_vec, running_vec, ready_hits, wait_hits;
    logic [IDX_W-1:0]      start_slot, ptr_inc;
    logic [EXT_W-1:0]      ticks_ext;
    logic [COUNT_BITS-1:0] ticks;
    logic [CMP_W-1:0]      next_ext;
    logic                  accept, out_free, hit_ready, hit_wait, cur_is_alarm, create_ok;

    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign ticks_ext  = EXT_W'(i_tick_count);
    assign ticks      = ticks_ext[COUNT_BITS-1:0];
    assign start_slot = (r_cur == IDX_W'(SLOT_COUNT - 1)) ? '0 : r_cur + 1'b1;
    assign ptr_inc    = (r_ptr == IDX_W'(SLOT_COUNT - 1)) ? '0 : r_ptr + 1'b1;
    assign hit_ready  = |ready_hits;
    assign hit_wait   = |wait_hits;
    assign cur_is_alarm = (CMP_W'(r_cur) == CMP_W'(r_alarm_slot));
    assign create_ok  = |(sel_vec & unused_vec & ~SLOT_COUNT'(1));

    always_comb begin
        cmd      = '0;
        cmd.state = rrss_pkg::ST_UNUSED;
        sel_slot = CMP_W'(r_cur);
        if (accept) begin
            unique case (i_operation)
                rrss_pkg::OP_TICK: begin
                    cmd.tick  = 1'b1;
                    cmd.set   = 1'b1;
                    cmd.state = rrss_pkg::ST_READY;
                    cmd.start = 1'b1;
                end
                rrss_pkg::OP_SLEEP: begin
                    cmd.set        = 1'b1;
                    cmd.state      = rrss_pkg::ST_WAITING;
                    cmd.load_sleep = 1'b1;
                    cmd.start      = 1'b1;
                end
                rrss_pkg::OP_EXIT: begin
                    cmd.set   = 1'b1;
                    cmd.state = rrss_pkg::ST_UNUSED;
                    cmd.start = 1'b1;
                end
                rrss_pkg::OP_CREATE: begin
                    cmd.create = 1'b1;
                    sel_slot   = CMP_W'(i_target_slot);
                end
                default: begin
                end
            endcase
        end else if (r_state == rrss_pkg::S_SCAN) begin
            cmd.shift = 1'b1;
        end else if ((r_state == rrss_pkg::S_WRITE) && out_free) begin
            cmd.set   = 1'b1;
            cmd.state = rrss_pkg::ST_RUNNING;
            sel_slot  = CMP_W'(r_next);
        end
    end

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        localparam int PREV = (g + SLOT_COUNT - 1) % SLOT_COUNT;

        assign sel_vec[g]     = (sel_slot == CMP_W'(g));
        assign start_vec[g]   = (start_slot == IDX_W'(g));
        assign unused_vec[g]  = stat[g].unused;
        assign running_vec[g] = stat[g].running;
        assign ready_hits[g]  = stat[g].hit_ready;
        assign wait_hits[g]   = stat[g].hit_wait;

        rrss_cell #(
            .COUNT_BITS (COUNT_BITS),
            .IS_IDLE    (g == 0)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_sel       (sel_vec[g]),
            .i_start     (start_vec[g]),
            .i_token     (token_vec[PREV]),
            .i_sleep_val (ticks),
            .o_token     (token_vec[g]),
            .o_stat      (stat[g])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_cur        = r_cur;
        n_next       = r_next;
        n_ptr        = r_ptr;
        n_steps      = r_steps;
        n_wait       = r_wait;
        n_fired      = r_fired;
        n_halt       = r_halt;
        n_alarm_left = r_alarm_left;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_slot   = r_out_slot;
        n_out_sw     = r_out_sw;
        n_out_fired  = r_out_fired;
        n_out_halt   = r_out_halt;
        next_ext     = CMP_W'(r_next);

        unique case (r_state)
            rrss_pkg::S_IDLE: begin
                if (accept) begin
                    n_op    = rrss_pkg::t_op'(i_operation);
                    n_next  = r_cur;
                    n_ptr   = start_slot;
                    n_steps = IDX_W'(SLOT_COUNT - 1);
                    n_wait  = 1'b0;
                    n_fired = 1'b0;
                    n_halt  = 1'b0;
                    n_state = rrss_pkg::S_WRITE;
                    unique case (i_operation)
                        rrss_pkg::OP_TICK: begin
                            n_state = rrss_pkg::S_SCAN;
                            if (r_alarm_left != '0) begin
                                n_alarm_left = r_alarm_left - 1'b1;
                                n_fired      = (r_alarm_left == COUNT_BITS'(1));
                            end
                        end
                        rrss_pkg::OP_SLEEP, rrss_pkg::OP_EXIT: begin
                            n_state = rrss_pkg::S_SCAN;
                        end
                        rrss_pkg::OP_ALARM: begin
                            if (cur_is_alarm) begin
                                n_alarm_left = ticks;
                            end
                        end
                        rrss_pkg::OP_CREATE: begin
                            if (create_ok && (i_target_slot == r_alarm_slot)) begin
                                n_alarm_left = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rrss_pkg::S_SCAN: begin
                n_ptr   = ptr_inc;
                n_steps = r_steps - 1'b1;
                n_wait  = r_wait || hit_wait;
                if (hit_ready) begin
                    n_next  = r_ptr;
                    n_state = rrss_pkg::S_WRITE;
                end else if (r_steps == IDX_W'(1)) begin
                    n_state = rrss_pkg::S_WRITE;
                    if ((r_op == rrss_pkg::OP_TICK) && (r_cur != '0)) begin
                        n_next = r_cur;
                    end else begin
                        n_next = '0;
                        n_halt = (r_op != rrss_pkg::OP_SLEEP) && !(r_wait || hit_wait);
                    end
                end
            end
            rrss_pkg::S_WRITE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_slot  = next_ext[3:0];
                    n_out_sw    = (r_next != r_cur);
                    n_out_fired = r_fired;
                    n_out_halt  = r_halt;
                    n_cur       = r_next;
                    n_state     = rrss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rrss_pkg::S_IDLE;
            r_cur        <= '0;
            r_alarm_left <= '0;
            r_alarm_slot <= 4'd1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur        <= n_cur;
            r_alarm_left <= n_alarm_left;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_alarm_slot <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_next      <= n_next;
        r_ptr       <= n_ptr;
        r_steps     <= n_steps;
        r_wait      <= n_wait;
        r_fired     <= n_fired;
        r_halt      <= n_halt;
        r_out_slot  <= n_out_slot;
        r_out_sw    <= n_out_sw;
        r_out_fired <= n_out_fired;
        r_out_halt  <= n_out_halt;
    end

    assign o_in_ready    = (r_state == rrss_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_next_slot   = r_out_slot;
    assign o_switched    = r_out_sw;
    assign o_alarm_fired = r_out_fired;
    assign o_shutdown    = r_out_halt;

    a_one_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrss_pkg::S_IDLE) |-> (running_vec == (SLOT_COUNT'(1) << r_cur)))
        else $error("Running slot does not match the current slot.");

    a_token_at_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrss_pkg::S_SCAN) |-> (token_vec == (SLOT_COUNT'(1) << r_ptr)))
        else $error("Scan token is not at the scan position.");

    a_pick_not_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == rrss_pkg::S_SCAN) && hit_ready) |-> (r_ptr != r_cur))
        else $error("Scan picked the current slot.");

endmodule
